// File: hw/rtl/rrht_pkg.sv
// Shared widths and the corner request type for the rounded rectangle hit test.
// No dependencies; used by rrht_corner, rounded_rect_hit_test and the testbench.
`timescale 1ns / 1ps

package rrht_pkg;

	// Coordinate and radius widths of the input beat.
	localparam int unsigned CoordW  = 16;
	localparam int unsigned RadiusW = 14;
	// A corner offset never exceeds the radius in magnitude.
	localparam int unsigned MagW    = RadiusW;
	localparam int unsigned SqW     = 2 * MagW;

	// Request handed from the region classifier to the corner distance test.
	typedef struct packed {
		logic               decided;    // Answer already known, no distance test.
		logic               early_hit;  // The known answer when decided is set.
		logic [MagW-1:0]    dx_mag;     // Offset from the corner circle center.
		logic [MagW-1:0]    dy_mag;
		logic [RadiusW-1:0] radius;
	} corner_req_t;

endpackage

// File: hw/rtl/rrht_corner.sv
// Corner distance test: squares the offsets and radius, then compares.
// Depends on rrht_pkg for widths and the corner_req_t type.
`timescale 1ns / 1ps

module rrht_corner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  rrht_pkg::corner_req_t req,
	output logic                done,
	output logic                hit
);

	logic                       valid_s3;
	logic                       decided_s3;
	logic                       early_hit_s3;
	logic [rrht_pkg::SqW-1:0]   dx_sq_s3;
	logic [rrht_pkg::SqW-1:0]   dy_sq_s3;
	logic [rrht_pkg::SqW-1:0]   r_sq_s3;
	logic [rrht_pkg::SqW:0]     dist_sq;
	logic                       hit_d;

	// Valid bits of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s3 <= req_valid;
			done     <= valid_s3;
		end
	end

	// Three independent squares, registered.
	always_ff @(posedge clk) begin
		decided_s3   <= req.decided;
		early_hit_s3 <= req.early_hit;
		dx_sq_s3     <= rrht_pkg::SqW'(req.dx_mag) * rrht_pkg::SqW'(req.dx_mag);
		dy_sq_s3     <= rrht_pkg::SqW'(req.dy_mag) * rrht_pkg::SqW'(req.dy_mag);
		r_sq_s3      <= rrht_pkg::SqW'(req.radius) * rrht_pkg::SqW'(req.radius);
	end

	// Sum of squares against the squared radius.
	assign dist_sq = {1'b0, dx_sq_s3} + {1'b0, dy_sq_s3};
	assign hit_d   = decided_s3 ? early_hit_s3 : (dist_sq <= {1'b0, r_sq_s3});

	always_ff @(posedge clk) begin
		hit <= hit_d;
	end

endmodule

// File: hw/rtl/rounded_rect_hit_test.sv
// Top level of the rounded rectangle hit test.
// Depends on rrht_pkg and instantiates rrht_corner.
`timescale 1ns / 1ps

// A new query is taken on every cycle in which start is high; busy is always
// low. Each query yields exactly one hit answer. The answer sits on the ports
// with done high for one cycle, and is accepted at the edge that ends that
// cycle. The receiver cannot stall, so the answer must be captured in that
// cycle. The answer passes through the pipeline in order: input register,
// region classification, offset squaring, and the final distance compare,
// one register each. Answers leave in the order queries were taken.
module rounded_rect_hit_test (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [rrht_pkg::CoordW-1:0] point_x,
	input  logic signed [rrht_pkg::CoordW-1:0] point_y,
	input  logic signed [rrht_pkg::CoordW-1:0] box_left,
	input  logic signed [rrht_pkg::CoordW-1:0] box_top,
	input  logic signed [rrht_pkg::CoordW-1:0] box_right,
	input  logic signed [rrht_pkg::CoordW-1:0] box_bottom,
	input  logic        [rrht_pkg::RadiusW-1:0] corner_radius,
	output logic                               done,
	output logic                               hit
);

	localparam int unsigned SumW  = rrht_pkg::CoordW + 1;
	localparam int unsigned DiffW = rrht_pkg::CoordW + 2;

	logic                                valid_s1;
	logic signed [SumW-1:0]              x_s1, y_s1, l_s1, t_s1, rt_s1, b_s1;
	logic        [rrht_pkg::RadiusW-1:0] r_s1;

	logic signed [SumW-1:0]              r_ext;
	logic signed [SumW-1:0]              lr, rr, tr, br;
	logic signed [DiffW-1:0]             dx_l, dx_r, dy_t, dy_b;
	logic signed [DiffW-1:0]             dx_sel, dy_sel;
	logic [DiffW-1:0]                    dx_abs, dy_abs;
	logic                                in_box, in_band, near_l, near_r, near_t, near_b;

	logic                                valid_s2;
	rrht_pkg::corner_req_t               req_d, req_s2;

	// The block never holds off a query.
	assign busy = 1'b0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_s1  <= SumW'(point_x);
			y_s1  <= SumW'(point_y);
			l_s1  <= SumW'(box_left);
			t_s1  <= SumW'(box_top);
			rt_s1 <= SumW'(box_right);
			b_s1  <= SumW'(box_bottom);
			r_s1  <= corner_radius;
		end
	end

	// Inner band edges, 17 bits so nothing wraps.
	assign r_ext = $signed({{(SumW - rrht_pkg::RadiusW){1'b0}}, r_s1});
	assign lr    = l_s1 + r_ext;
	assign rr    = rt_s1 - r_ext;
	assign tr    = t_s1 + r_ext;
	assign br    = b_s1 - r_ext;

	// Region classification.
	assign in_box  = (x_s1 >= l_s1) && (x_s1 <= rt_s1) && (y_s1 >= t_s1) && (y_s1 <= b_s1);
	assign in_band = ((x_s1 >= lr) && (x_s1 <= rr)) || ((y_s1 >= tr) && (y_s1 <= br));
	assign near_l  = x_s1 <= lr;
	assign near_r  = x_s1 >= rr;
	assign near_t  = y_s1 <= tr;
	assign near_b  = y_s1 >= br;

	// Offsets from each candidate circle center.
	assign dx_l = DiffW'(x_s1) - DiffW'(lr);
	assign dx_r = DiffW'(x_s1) - DiffW'(rr);
	assign dy_t = DiffW'(y_s1) - DiffW'(tr);
	assign dy_b = DiffW'(y_s1) - DiffW'(br);

	// Decide outside-box, zero-radius and band points early; else pick the first corner whose quadrant holds the point.
	always_comb begin
		dx_sel            = dx_l;
		dy_sel            = dy_t;
		req_d.decided     = 1'b1;
		req_d.early_hit   = 1'b0;
		priority if (!in_box) begin
			req_d.early_hit = 1'b0;
		end else if (r_s1 == '0) begin
			req_d.early_hit = 1'b1;
		end else if (in_band) begin
			req_d.early_hit = 1'b1;
		end else if (near_l && near_t) begin
			req_d.decided = 1'b0;
		end else if (near_r && near_t) begin
			req_d.decided = 1'b0;
			dx_sel        = dx_r;
		end else if (near_l && near_b) begin
			req_d.decided = 1'b0;
			dy_sel        = dy_b;
		end else if (near_r && near_b) begin
			req_d.decided = 1'b0;
			dx_sel        = dx_r;
			dy_sel        = dy_b;
		end else begin
			req_d.early_hit = 1'b0;
		end

		// Within a corner quadrant the offsets never exceed the radius.
		dx_abs       = dx_sel[DiffW-1] ? DiffW'(-dx_sel) : DiffW'(dx_sel);
		dy_abs       = dy_sel[DiffW-1] ? DiffW'(-dy_sel) : DiffW'(dy_sel);
		req_d.dx_mag = dx_abs[rrht_pkg::MagW-1:0];
		req_d.dy_mag = dy_abs[rrht_pkg::MagW-1:0];
		req_d.radius = r_s1;
	end

	// Classification register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		req_s2 <= req_d;
	end

	// Corner distance test and result register.
	rrht_corner u_corner (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (valid_s2),
		.req       (req_s2),
		.done      (done),
		.hit       (hit)
	);

endmodule

// File: sim/rounded_rect_hit_test_tb.sv
// Self-checking testbench for the rounded rectangle hit test.
// Depends on rrht_pkg for the field widths and on rounded_rect_hit_test as the block under test.
`timescale 1ns / 1ps

// One query beat as presented on the input ports.
typedef struct {
	logic signed [rrht_pkg::CoordW-1:0]  px;
	logic signed [rrht_pkg::CoordW-1:0]  py;
	logic signed [rrht_pkg::CoordW-1:0]  left;
	logic signed [rrht_pkg::CoordW-1:0]  top;
	logic signed [rrht_pkg::CoordW-1:0]  right;
	logic signed [rrht_pkg::CoordW-1:0]  bottom;
	logic        [rrht_pkg::RadiusW-1:0] radius;
} hit_query_t;

// Keeps the expected hit answers in order and compares each answer beat.
class hit_scoreboard;
	bit expected_hits[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// Computes whether the point lies inside the rounded rectangle.
	function bit predict_hit(hit_query_t q);
		logic signed [16:0] x, y, l, t, rt, b, r, lr, rr, tr, br;
		logic signed [17:0] dx, dy;
		longint dist_sq, rad_sq;
		x  = {q.px[15], q.px};
		y  = {q.py[15], q.py};
		l  = {q.left[15], q.left};
		t  = {q.top[15], q.top};
		rt = {q.right[15], q.right};
		b  = {q.bottom[15], q.bottom};
		r  = {3'b000, q.radius};
		if (x < l || x > rt || y < t || y > b)
			return 1'b0;
		if (r == 0)
			return 1'b1;
		lr = l + r;
		rr = rt - r;
		tr = t + r;
		br = b - r;
		// Points in either straight band are inside without a distance test.
		if (x >= lr && x <= rr)
			return 1'b1;
		if (y >= tr && y <= br)
			return 1'b1;
		// The first corner whose quadrant holds the point decides.
		if (x <= lr && y <= tr) begin
			dx = x - lr;
			dy = y - tr;
		end else if (x >= rr && y <= tr) begin
			dx = x - rr;
			dy = y - tr;
		end else if (x <= lr && y >= br) begin
			dx = x - lr;
			dy = y - br;
		end else if (x >= rr && y >= br) begin
			dx = x - rr;
			dy = y - br;
		end else begin
			return 1'b0;
		end
		dist_sq = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
		rad_sq  = longint'(r) * longint'(r);
		return dist_sq <= rad_sq;
	endfunction

	function void note_query(hit_query_t q);
		expected_hits.push_back(predict_hit(q));
	endfunction

	function void check_answer(logic actual);
		bit want;
		if (expected_hits.size() == 0) begin
			$error("hit: answer with no query pending, expected none, actual %0b", actual);
			errors++;
			return;
		end
		want = expected_hits.pop_front();
		if (actual !== want) begin
			$error("hit mismatch: expected %0b, actual %0b", want, actual);
			errors++;
		end
	endfunction

	function int pending();
		return expected_hits.size();
	endfunction
endclass

module rounded_rect_hit_test_tb;

	localparam int StallLimit  = 2000;
	localparam int PhaseItems  = 630;
	localparam int DrainCycles = 10;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic signed [rrht_pkg::CoordW-1:0]  point_x = '0;
	logic signed [rrht_pkg::CoordW-1:0]  point_y = '0;
	logic signed [rrht_pkg::CoordW-1:0]  box_left = '0;
	logic signed [rrht_pkg::CoordW-1:0]  box_top = '0;
	logic signed [rrht_pkg::CoordW-1:0]  box_right = '0;
	logic signed [rrht_pkg::CoordW-1:0]  box_bottom = '0;
	logic        [rrht_pkg::RadiusW-1:0] corner_radius = '0;
	logic                                done;
	logic                                hit;

	hit_scoreboard sb;
	int            quiet_cycles = 0;

	rounded_rect_hit_test dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.point_x       (point_x),
		.point_y       (point_y),
		.box_left      (box_left),
		.box_top       (box_top),
		.box_right     (box_right),
		.box_bottom    (box_bottom),
		.corner_radius (corner_radius),
		.done          (done),
		.hit           (hit)
	);

	// Free-running clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Saturates a coordinate to the signed 16-bit range.
	function automatic logic signed [15:0] clip_coord(int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic hit_query_t make_query(int px, int py, int l, int t, int rt, int b,
		int r);
		hit_query_t q;
		q.px     = clip_coord(px);
		q.py     = clip_coord(py);
		q.left   = clip_coord(l);
		q.top    = clip_coord(t);
		q.right  = clip_coord(rt);
		q.bottom = clip_coord(b);
		q.radius = (r > 16383) ? 14'h3fff : ((r < 0) ? 14'h0 : r[13:0]);
		return q;
	endfunction

	// Picks a point near a corner of a well-formed box or anywhere in or just
	// around it, with some inverted boxes and some uniform noise mixed in.
	function automatic hit_query_t random_query();
		hit_query_t q;
		logic signed [15:0] swap;
		int w, h, l, t, r, half, cx, cy, px, py;
		int kind;
		kind = int'($urandom_range(0, 9));
		if (kind == 0) begin
			q.px     = 16'($urandom());
			q.py     = 16'($urandom());
			q.left   = 16'($urandom());
			q.top    = 16'($urandom());
			q.right  = 16'($urandom());
			q.bottom = 16'($urandom());
			q.radius = 14'($urandom());
			return q;
		end
		w = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535))
			: int'($urandom_range(0, 300));
		h = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535))
			: int'($urandom_range(0, 300));
		l = int'($urandom_range(0, 65535)) - 32768;
		t = int'($urandom_range(0, 65535)) - 32768;
		if (l + w > 32767)
			l = 32767 - w;
		if (t + h > 32767)
			t = 32767 - h;
		half = ((w < h) ? w : h) / 2;
		case ($urandom_range(0, 3))
			0: r = int'($urandom_range(0, half));
			1: r = int'($urandom_range(0, 16383));
			2: r = half + int'($urandom_range(0, 3));
			default: r = int'($urandom_range(0, 20));
		endcase
		if (r > 16383)
			r = 16383;
		if ($urandom_range(0, 2) == 0) begin
			px = l - 2 + int'($urandom_range(0, w + 4));
			py = t - 2 + int'($urandom_range(0, h + 4));
		end else begin
			cx = $urandom_range(0, 1) ? l + r : l + w - r;
			cy = $urandom_range(0, 1) ? t + r : t + h - r;
			px = cx - r - 2 + int'($urandom_range(0, 2 * r + 4));
			py = cy - r - 2 + int'($urandom_range(0, 2 * r + 4));
		end
		q = make_query(px, py, l, t, l + w, t + h, r);
		// An inverted box is a broken query that must always miss.
		if (kind == 1 && q.left != q.right) begin
			swap    = q.left;
			q.left  = q.right;
			q.right = swap;
		end else if (kind == 2 && q.top != q.bottom) begin
			swap     = q.top;
			q.top    = q.bottom;
			q.bottom = swap;
		end
		return q;
	endfunction

	// Presents one query beat after a random gap and holds it until taken.
	task automatic send_query(hit_query_t q, int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		point_x       <= q.px;
		point_y       <= q.py;
		box_left      <= q.left;
		box_top       <= q.top;
		box_right     <= q.right;
		box_bottom    <= q.bottom;
		corner_radius <= q.radius;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Edge cases: extremes, each band, each corner on both sides of the arc.
	task automatic send_directed(int idle_pct);
		send_query(make_query(0, 0, -10, -10, 10, 10, 0), idle_pct);
		send_query(make_query(-32768, -32768, -32768, -32768, 32767, 32767, 0), idle_pct);
		send_query(make_query(32767, 32767, -32768, -32768, 32767, 32767, 0), idle_pct);
		send_query(make_query(-32768, -32768, -32768, -32768, 32767, 32767, 16383), idle_pct);
		send_query(make_query(32767, 32767, -32768, -32768, 32767, 32767, 16383), idle_pct);
		send_query(make_query(-16385, -32768, -32768, -32768, 32767, 32767, 16383), idle_pct);
		send_query(make_query(0, 0, -32768, -32768, 32767, 32767, 16383), idle_pct);
		// Points just outside each side of the box.
		send_query(make_query(-1, 50, 0, 0, 100, 100, 0), idle_pct);
		send_query(make_query(101, 50, 0, 0, 100, 100, 0), idle_pct);
		send_query(make_query(50, -1, 0, 0, 100, 100, 0), idle_pct);
		send_query(make_query(50, 101, 0, 0, 100, 100, 0), idle_pct);
		// Inverted boxes.
		send_query(make_query(0, 0, 10, -10, -10, 10, 3), idle_pct);
		send_query(make_query(0, 0, -10, 10, 10, -10, 3), idle_pct);
		// Vertical and horizontal bands on the box edge.
		send_query(make_query(50, 0, 0, 0, 100, 100, 10), idle_pct);
		send_query(make_query(0, 50, 0, 0, 100, 100, 10), idle_pct);
		// Each corner, once just inside the arc and once just outside.
		send_query(make_query(3, 3, 0, 0, 100, 100, 10), idle_pct);
		send_query(make_query(2, 2, 0, 0, 100, 100, 10), idle_pct);
		send_query(make_query(97, 3, 0, 0, 100, 100, 10), idle_pct);
		send_query(make_query(98, 2, 0, 0, 100, 100, 10), idle_pct);
		send_query(make_query(3, 97, 0, 0, 100, 100, 10), idle_pct);
		send_query(make_query(2, 98, 0, 0, 100, 100, 10), idle_pct);
		send_query(make_query(97, 97, 0, 0, 100, 100, 10), idle_pct);
		send_query(make_query(98, 98, 0, 0, 100, 100, 10), idle_pct);
		// Radius larger than half the box, and a single pixel box.
		send_query(make_query(2, 2, 0, 0, 4, 4, 10), idle_pct);
		send_query(make_query(2, 2, 0, 0, 4, 4, 3), idle_pct);
		send_query(make_query(5, 5, 5, 5, 5, 5, 1), idle_pct);
	endtask

	// Stimulus: reset, directed beats, then three random phases.
	initial begin
		int idle_pct;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed(13);
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 13 : ((phase == 1) ? 50 : 0);
			for (int i = 0; i < PhaseItems; i++)
				send_query(random_query(), idle_pct);
		end
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Records each accepted query beat and checks each answer beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_query('{point_x, point_y, box_left, box_top, box_right, box_bottom,
					corner_radius});
			if (done)
				sb.check_answer(hit);
		end
	end

	// Ends the run if neither side moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule
